>>> hdl/dep_pkg.sv
// Shared types and constants for the double-ended priority queue.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package dep_pkg;

  // Fixed field widths of the input and result words.
  localparam int ACTION_BITS = 2;
  localparam int FIELD_BITS  = 32;
  localparam int COUNT_BITS  = 9;

  // Default sizing of the queue.
  localparam int DEP_CAPACITY   = 256;
  localparam int DEP_VALUE_BITS = 32;

  // Action codes carried by an input word.
  typedef enum logic [ACTION_BITS-1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DEL_MAX = 2'd1,
    ACT_DEL_MIN = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

endpackage

`default_nettype wire

>>> hdl/dep_ifs.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on dep_pkg for the field widths.
`default_nettype none

interface dep_in_if
  import dep_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic [ACTION_BITS-1:0]       action;
  logic signed [FIELD_BITS-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface dep_out_if
  import dep_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic                         is_empty;
  logic signed [FIELD_BITS-1:0] max_value;
  logic signed [FIELD_BITS-1:0] min_value;
  logic [COUNT_BITS-1:0]        count;
  logic                         dropped;

  modport source (output valid, output is_empty, output max_value, output min_value,
                  output count, output dropped, input ready);
  modport sink   (input valid, input is_empty, input max_value, input min_value,
                  input count, input dropped, output ready);
endinterface

`default_nettype wire

>>> hdl/dep_store.sv
// Sorted value store: one write port and two registered read ports.
// Depends on dep_pkg for the default parameter values, through the wildcard import.
`default_nettype none

module dep_store
  import dep_pkg::*;
#(
  parameter int DEPTH = DEP_CAPACITY,
  parameter int WIDTH = DEP_VALUE_BITS,
  parameter int AW    = $clog2(DEP_CAPACITY)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first-come; reads are registered and return the stored word in the cycle after the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

>>> hdl/double_ended_priority_queue_core.sv
// Double-ended priority queue over signed values. Held values live in a circular store in
// ascending order: the minimum sits at the head pointer and the maximum at head plus count
// minus one. Deleting the maximum or minimum, and clearing, only move the count or the head,
// then the result is fetched and captured. An insert walks down from the maximum with one
// shared comparator, moving each larger entry up by one slot per cycle until the new value's
// place is found; equal values already held stay below it. A refused insert into a full
// queue goes straight to the fetch. Input ready is high only while the sequencer is idle; a
// finished result sits in an output register, so the next word is taken while the previous
// result waits.
// Depends on dep_pkg, the channel interfaces in dep_ifs.sv and dep_store.
`default_nettype none

module double_ended_priority_queue_core
  import dep_pkg::*;
#(
  parameter int CAPACITY   = DEP_CAPACITY,
  parameter int VALUE_BITS = DEP_VALUE_BITS
) (
  input wire logic clk,
  input wire logic rst_n,
  dep_in_if.sink   in_ch,
  dep_out_if.source out_ch
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUT,
    ST_FETCH,
    ST_CAPT
  } state_t;

  state_t                       state_r;
  logic [CW-1:0]                count_r;
  logic [AW-1:0]                head_r;
  logic [AW-1:0]                scan_r;
  logic signed [VALUE_BITS-1:0] key_r;
  logic                         dropped_r;

  logic                         out_valid_r;
  logic                         out_empty_r;
  logic [FIELD_BITS-1:0]        out_max_r;
  logic [FIELD_BITS-1:0]        out_min_r;
  logic [COUNT_BITS-1:0]        out_count_r;
  logic                         out_dropped_r;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [VALUE_BITS-1:0]        mem_wdata;
  logic [AW-1:0]                mem_raddr_a;
  logic [AW-1:0]                mem_raddr_b;
  logic [VALUE_BITS-1:0]        mem_rdata_a;
  logic [VALUE_BITS-1:0]        mem_rdata_b;

  logic                         in_fire;
  logic                         out_free;
  logic signed [63:0]           in_ext;
  logic signed [VALUE_BITS-1:0] in_key;
  logic [AW-1:0]                max_addr;
  logic [AW:0]                  top_off;
  logic                         key_below;
  logic signed [63:0]           max_ext;
  logic signed [63:0]           min_ext;
  logic [CW+COUNT_BITS-1:0]     count_wide;

  // Physical slot of an offset from the head, wrapping at the store depth.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [AW:0] off);
    logic [AW+1:0] sum;
    sum = (AW+2)'(base) + (AW+2)'(off);
    if (sum >= (AW+2)'(CAPACITY)) begin
      sum = sum - (AW+2)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  dep_store #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_BITS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  // Handshake and input value conversion.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && (state_r == ST_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ext      = 64'(in_ch.value);
  assign in_key      = in_ext[VALUE_BITS-1:0];

  // Offset of the largest held value, and the shared compare of the scan.
  assign top_off   = (count_r == '0) ? '0 : (AW+1)'(count_r - 1'b1);
  assign max_addr  = slot(head_r, top_off);
  assign key_below = key_r < $signed(mem_rdata_a);

  // Store port control.
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = head_r;
    mem_wdata   = key_r;
    mem_raddr_a = head_r;
    mem_raddr_b = max_addr;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (action_t'(in_ch.action) == ACT_INSERT) &&
            (count_r != CW'(CAPACITY))) begin
          if (count_r == '0) begin
            mem_we    = 1'b1;
            mem_wdata = in_key;
          end else begin
            mem_raddr_a = max_addr;
          end
        end
      end
      ST_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = slot(head_r, (AW+1)'(scan_r) + 1'b1);
        if (key_below) begin
          mem_wdata = mem_rdata_a;
          if (scan_r != '0) begin
            mem_raddr_a = slot(head_r, (AW+1)'(scan_r - 1'b1));
          end
        end
      end
      ST_PUT: begin
        mem_we = 1'b1;
      end
      ST_FETCH, ST_CAPT: begin
      end
      default: begin
      end
    endcase
  end

  // Result fields from the two read ports.
  assign max_ext    = 64'($signed(mem_rdata_b));
  assign min_ext    = 64'($signed(mem_rdata_a));
  assign count_wide = (CW+COUNT_BITS)'(count_r);

  // Sequencer, queue state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A finished result loads the output register; a taken word empties it.
      if ((state_r == ST_CAPT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            dropped_r <= (action_t'(in_ch.action) == ACT_INSERT) &&
                         (count_r == CW'(CAPACITY));
            state_r   <= ((action_t'(in_ch.action) == ACT_INSERT) && (count_r != '0) &&
                          (count_r != CW'(CAPACITY))) ? ST_SCAN : ST_FETCH;
            unique case (action_t'(in_ch.action))
              ACT_INSERT: begin
                if (count_r != CW'(CAPACITY)) begin
                  key_r <= in_key;
                  if (count_r == '0) begin
                    count_r <= count_r + 1'b1;
                  end else begin
                    scan_r <= AW'(count_r - 1'b1);
                  end
                end
              end
              ACT_DEL_MAX: begin
                if (count_r != '0) begin
                  count_r <= count_r - 1'b1;
                end
              end
              ACT_DEL_MIN: begin
                if (count_r != '0) begin
                  head_r  <= slot(head_r, (AW+1)'(1));
                  count_r <= count_r - 1'b1;
                end
              end
              ACT_CLEAR: begin
                count_r <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (key_below) begin
            if (scan_r == '0) begin
              state_r <= ST_PUT;
            end else begin
              scan_r <= scan_r - 1'b1;
            end
          end else begin
            count_r <= count_r + 1'b1;
            state_r <= ST_FETCH;
          end
        end
        ST_PUT: begin
          count_r <= count_r + 1'b1;
          state_r <= ST_FETCH;
        end
        ST_FETCH: begin
          state_r <= ST_CAPT;
        end
        ST_CAPT: begin
          if (out_free) begin
            out_empty_r   <= (count_r == '0);
            out_max_r     <= (count_r == '0) ? '0 : max_ext[FIELD_BITS-1:0];
            out_min_r     <= (count_r == '0) ? '0 : min_ext[FIELD_BITS-1:0];
            out_count_r   <= count_wide[COUNT_BITS-1:0];
            out_dropped_r <= dropped_r;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.is_empty  = out_empty_r;
  assign out_ch.max_value = out_max_r;
  assign out_ch.min_value = out_min_r;
  assign out_ch.count     = out_count_r;
  assign out_ch.dropped   = out_dropped_r;

  // The queue never holds more values than the store has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("held count exceeds capacity");

  // The insert scan stays inside the held entries.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (CW'(scan_r) < count_r))
    else $error("insert scan outside held entries");

  // A refused insert is reported only for a full queue.
  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CAPT && out_free && dropped_r) |-> (count_r == CW'(CAPACITY)))
    else $error("drop reported with room left");

  // An accepted word always starts the sequencer.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("accepted word did not start processing");

endmodule

`default_nettype wire

>>> bench/dep_queue_checker.sv
// Checker for the double-ended priority queue: watches both channels, predicts each result word.
// Depends on dep_pkg and the channel interfaces in dep_ifs.sv.

module dep_queue_checker
  import dep_pkg::*;
#(
  parameter int CAPACITY = DEP_CAPACITY
) (
  input  logic clk,
  input  logic rst_n,
  dep_in_if    in_ch,
  dep_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                         is_empty;
    logic signed [FIELD_BITS-1:0] max_value;
    logic signed [FIELD_BITS-1:0] min_value;
    logic [COUNT_BITS-1:0]        count;
    logic                         dropped;
  } queue_state_t;

  // Held values in ascending order, and the result words still owed by the block.
  logic signed [FIELD_BITS-1:0] held_vals[$];
  queue_state_t                 expected_states[$];
  int                           errs;

  initial begin
    errs       = 0;
    fail_count = 0;
    pending    = 0;
  end

  // Apply one accepted word to the predicted queue and record the state it reports.
  task automatic apply_action(input action_t act, input logic signed [FIELD_BITS-1:0] val);
    queue_state_t st;
    int           pos;
    st = '0;
    pos = 0;
    case (act)
      ACT_INSERT: begin
        if (held_vals.size() >= CAPACITY) begin
          st.dropped = 1'b1;
        end else begin
          // Equal values go after the copies already held.
          while (pos < held_vals.size() && held_vals[pos] <= val) pos++;
          held_vals.insert(pos, val);
        end
      end
      ACT_DEL_MAX: begin
        if (held_vals.size() > 0) void'(held_vals.pop_back());
      end
      ACT_DEL_MIN: begin
        if (held_vals.size() > 0) void'(held_vals.pop_front());
      end
      default: begin
        held_vals.delete();
      end
    endcase
    if (held_vals.size() == 0) begin
      st.is_empty = 1'b1;
    end else begin
      st.max_value = held_vals[held_vals.size() - 1];
      st.min_value = held_vals[0];
    end
    st.count = COUNT_BITS'(held_vals.size());
    expected_states.push_back(st);
  endtask

  // Predict on accepted input words, compare accepted result words against the oldest prediction.
  always @(posedge clk) begin
    queue_state_t want;
    if (!rst_n) begin
      held_vals.delete();
      expected_states.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_action(action_t'(in_ch.action), in_ch.value);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_states.size() == 0) begin
          $error("result word arrived with no prediction pending");
          errs++;
        end else begin
          want = expected_states.pop_front();
          if (out_ch.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, out_ch.is_empty);
            errs++;
          end
          if (out_ch.max_value !== want.max_value) begin
            $error("max_value: expected %0d, got %0d", want.max_value, out_ch.max_value);
            errs++;
          end
          if (out_ch.min_value !== want.min_value) begin
            $error("min_value: expected %0d, got %0d", want.min_value, out_ch.min_value);
            errs++;
          end
          if (out_ch.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_ch.count);
            errs++;
          end
          if (out_ch.dropped !== want.dropped) begin
            $error("dropped: expected %0d, got %0d", want.dropped, out_ch.dropped);
            errs++;
          end
        end
      end
    end
    fail_count <= errs;
    pending    <= expected_states.size();
  end

endmodule

>>> bench/double_ended_priority_queue_core_tb.sv
// Top of the priority queue bench: clock, reset, input and result stimulus, and the verdict.
// Depends on dep_pkg, dep_ifs.sv, the queue core and dep_queue_checker.

module double_ended_priority_queue_core_tb
  import dep_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // The limit leaves a wide margin over the slowest run of about 800 words.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 300;

  localparam logic signed [FIELD_BITS-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [FIELD_BITS-1:0] VAL_MIN = 32'sh8000_0000;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   fail_count;
  int   pending;
  bit   calm;

  dep_in_if  in_ch ();
  dep_out_if out_ch ();

  double_ended_priority_queue_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dep_queue_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 20 ns clock.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop if the block hangs.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Draw a value: full range, a narrow band for duplicates, or one of the extremes, zero or minus one.
  function automatic logic signed [FIELD_BITS-1:0] pick_value();
    logic signed [FIELD_BITS-1:0] v;
    case ($urandom_range(0, 3))
      0, 1: v = $urandom;
      2:    v = $signed($urandom_range(0, 16)) - 8;
      default: begin
        case ($urandom_range(0, 5))
          0: v = VAL_MAX;
          1: v = VAL_MIN;
          2: v = VAL_MAX - 1;
          3: v = VAL_MIN + 1;
          4: v = '0;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  // Send one word after a random gap, then hold it until the block takes it.
  task automatic send_word(input action_t act, input logic signed [FIELD_BITS-1:0] val);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.value  <= val;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // A stretch of random words with a given mix of inserts and clears; the rest are deletes.
  task automatic run_segment(input int n_words, input int ins_pct, input int clr_pct);
    int      r;
    action_t act;
    for (int i = 0; i < n_words; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < clr_pct) act = ACT_CLEAR;
      else if (r < clr_pct + ins_pct) act = ACT_INSERT;
      else if ($urandom_range(0, 1) == 1) act = ACT_DEL_MAX;
      else act = ACT_DEL_MIN;
      // Non-insert words carry random junk in the value field.
      send_word(act, act == ACT_INSERT ? pick_value() : $signed(FIELD_BITS'($urandom)));
    end
  endtask

  // Result side: stall a random number of cycles before taking each word.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Input stimulus and verdict.
  initial begin
    calm = 1'b0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.action <= ACT_INSERT;
    in_ch.value  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: deletes and a clear on an empty queue, extremes, duplicates, drain to empty.
    send_word(ACT_CLEAR, 32'sd0);
    send_word(ACT_DEL_MAX, 32'sd0);
    send_word(ACT_DEL_MIN, 32'sd0);
    send_word(ACT_INSERT, VAL_MAX);
    send_word(ACT_INSERT, VAL_MIN);
    send_word(ACT_INSERT, 32'sd0);
    send_word(ACT_INSERT, -32'sd1);
    send_word(ACT_INSERT, 32'sd1);
    send_word(ACT_INSERT, 32'sd5);
    send_word(ACT_INSERT, 32'sd5);
    send_word(ACT_DEL_MAX, VAL_MIN);
    send_word(ACT_DEL_MIN, VAL_MAX);
    send_word(ACT_DEL_MAX, 32'sd0);
    send_word(ACT_DEL_MIN, 32'sd0);
    send_word(ACT_INSERT, 32'sd5);
    send_word(ACT_CLEAR, -32'sd1);
    send_word(ACT_INSERT, -32'sd5);
    send_word(ACT_DEL_MIN, 32'sd0);
    send_word(ACT_DEL_MAX, 32'sd0);
    send_word(ACT_INSERT, 32'sd7);
    send_word(ACT_INSERT, 32'sd7);
    send_word(ACT_DEL_MAX, 32'sd0);
    send_word(ACT_DEL_MAX, 32'sd0);

    // Random: fill past capacity so inserts are dropped, drain, mix, then refill.
    send_word(ACT_CLEAR, 32'sd0);
    run_segment(290, 97, 0);
    run_segment(160, 15, 0);
    run_segment(200, 50, 3);
    run_segment(100, 85, 0);

    in_ch.valid <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/dep_pkg.sv
hdl/dep_ifs.sv
hdl/dep_store.sv
hdl/double_ended_priority_queue_core.sv
bench/dep_queue_checker.sv
bench/double_ended_priority_queue_core_tb.sv
